FILE: rtl/core/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared constants, result type and lead byte decode for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned CodeW    = 21;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ExpW     = 2;
  localparam int unsigned FifoDepth = 4;

  localparam logic [CodeW-1:0] ReplacementChar = CodeW'(21'h00FFFD);

  typedef logic [CodeW-1:0] code_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [ExpW-1:0]  exp_t;

  typedef struct packed {
    code_t code_point;
    logic  run_last;
    logic  text_done;
  } result_t;

  typedef struct packed {
    logic  emit;
    code_t cp;
    exp_t  expect_cnt;
    code_t partial;
  } lead_t;

  function automatic lead_t decode_lead(byte_t b);
    lead_t l;
    l.emit       = 1'b0;
    l.cp         = ReplacementChar;
    l.expect_cnt = '0;
    l.partial    = '0;
    if (b[7] == 1'b0) begin
      l.emit = 1'b1;
      l.cp   = {13'd0, b};
    end else if ((b & 8'hE0) == 8'hC0) begin
      l.partial    = {16'd0, b[4:0]};
      l.expect_cnt = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      l.partial    = {17'd0, b[3:0]};
      l.expect_cnt = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      l.partial    = {18'd0, b[2:0]};
      l.expect_cnt = 2'd3;
    end else begin
      l.emit = 1'b1;
      l.cp   = ReplacementChar;
    end
    return l;
  endfunction

endpackage

FILE: rtl/core/u8dec_in_if.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder byte channel
// Valid/ready channel carrying one raw byte and the end-of-text flag.
// ----------------------------------------------------------------------------
interface u8dec_in_if;
  import u8dec_pkg::*;

  logic  valid;
  logic  ready;
  byte_t byte_in;
  logic  end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

FILE: rtl/core/u8dec_out_if.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder code point channel
// Valid/ready channel carrying one decoded code point and its markers.
// ----------------------------------------------------------------------------
interface u8dec_out_if;
  import u8dec_pkg::*;

  logic  valid;
  logic  ready;
  code_t code_point;
  logic  run_last;
  logic  text_done;

  modport source (output valid, output code_point, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input code_point, input run_last, input text_done,
                  output ready);
endinterface

FILE: rtl/core/utf8_decoder_with_replacement_core.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder with replacement
// Decodes a byte stream into code points, replacing bad lead bytes, stray continuations and truncated sequences.
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever the four-entry result queue has room
// for two results; each transfer updates the sequence state and pushes zero,
// one or two code points, which leave the queue one per cycle while the sink
// is ready. The sustained rate is one byte per cycle while each byte yields at
// most one result and the sink does not stall, and is bounded by the single
// output transfer per cycle otherwise. Each result is registered in the queue.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement_core (
  input logic        clk,
  input logic        rst_n,
  u8dec_in_if.sink   in_ch,
  u8dec_out_if.source out_ch
);
  import u8dec_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  exp_t    expect_r, expect_nxt;
  code_t   partial_r, partial_nxt;
  result_t fifo_r [FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;

  logic    in_fire, out_fire;
  lead_t   lead;
  logic [1:0] n_res;
  code_t   res0, res1;
  logic    cont;
  exp_t    exp_dec;
  result_t ent0, ent1;

  assign in_ch.ready = (count_r <= CntW'(FifoDepth - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (count_r != '0);
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign out_ch.code_point = fifo_r[rd_ptr_r].code_point;
  assign out_ch.run_last   = fifo_r[rd_ptr_r].run_last;
  assign out_ch.text_done  = fifo_r[rd_ptr_r].text_done;

  assign cont = (in_ch.byte_in[7:6] == 2'b10);
  assign lead = decode_lead(in_ch.byte_in);
  assign exp_dec = expect_r - 2'd1;

  always_comb begin
    n_res       = 2'd0;
    res0        = ReplacementChar;
    res1        = ReplacementChar;
    expect_nxt  = expect_r;
    partial_nxt = partial_r;
    if (expect_r != '0) begin
      if (cont) begin
        expect_nxt  = exp_dec;
        partial_nxt = {partial_r[CodeW-7:0], in_ch.byte_in[5:0]};
        if (exp_dec == '0) begin
          n_res       = 2'd1;
          res0        = {partial_r[CodeW-7:0], in_ch.byte_in[5:0]};
          partial_nxt = '0;
        end
      end else begin
        n_res       = 2'd1;
        res0        = ReplacementChar;
        expect_nxt  = lead.expect_cnt;
        partial_nxt = lead.partial;
        if (lead.emit) begin
          n_res = 2'd2;
          res1  = lead.cp;
        end
      end
    end else begin
      expect_nxt  = lead.expect_cnt;
      partial_nxt = lead.partial;
      if (lead.emit) begin
        n_res = 2'd1;
        res0  = lead.cp;
      end
    end
    if (in_ch.end_of_text) begin
      if (expect_nxt != '0) begin
        if (n_res == 2'd0) begin
          res0 = ReplacementChar;
        end else begin
          res1 = ReplacementChar;
        end
        n_res = n_res + 2'd1;
      end
      expect_nxt  = '0;
      partial_nxt = '0;
    end
    ent0.code_point = res0;
    ent0.run_last   = (n_res == 2'd1);
    ent0.text_done  = (n_res == 2'd1) && in_ch.end_of_text;
    ent1.code_point = res1;
    ent1.run_last   = 1'b1;
    ent1.text_done  = in_ch.end_of_text;
  end

  always_comb begin
    count_nxt = count_r;
    if (in_fire) begin
      count_nxt = count_nxt + CntW'(n_res);
    end
    if (out_fire) begin
      count_nxt = count_nxt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r  <= '0;
      partial_r <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        expect_r  <= expect_nxt;
        partial_r <= partial_nxt;
        wr_ptr_r  <= wr_ptr_r + PtrW'(n_res);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (n_res != 2'd0)) begin
      fifo_r[wr_ptr_r] <= ent0;
    end
    if (in_fire && (n_res == 2'd2)) begin
      fifo_r[wr_ptr_r + PtrW'(1)] <= ent1;
    end
  end

endmodule

FILE: test/utf8_decoder_with_replacement_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder with replacement testbench
// Feeds directed byte strings and then random texts, mostly well-formed, into
// the decoder under varying source idling and sink stalls. Every code point
// transfer is compared with the directed table or a local sequence decoder.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement_core_tb;
  import u8dec_pkg::*;

  localparam int DirRows    = 25;
  localparam int PhaseItems = 481;
  localparam int DrainTail  = 20;
  localparam int StallLimit = 4000;

  typedef struct {
    byte_t b;
    logic  eot;
    bit    typed;
    int    n;
    code_t cp0;
    code_t cp1;
  } text_row_t;

  text_row_t dir_rows [DirRows] = '{
    '{8'h00, 1'b0, 1'b1, 1, 21'h000000, 21'h0},
    '{8'h7F, 1'b0, 1'b1, 1, 21'h00007F, 21'h0},
    '{8'h80, 1'b0, 1'b1, 1, ReplacementChar, 21'h0},
    '{8'hF8, 1'b0, 1'b1, 1, ReplacementChar, 21'h0},
    '{8'hFF, 1'b0, 1'b1, 1, ReplacementChar, 21'h0},
    '{8'hC2, 1'b0, 1'b1, 0, 21'h0, 21'h0},
    '{8'hA9, 1'b0, 1'b1, 1, 21'h0000A9, 21'h0},
    '{8'hE2, 1'b0, 1'b1, 0, 21'h0, 21'h0},
    '{8'h82, 1'b0, 1'b1, 0, 21'h0, 21'h0},
    '{8'hAC, 1'b0, 1'b1, 1, 21'h0020AC, 21'h0},
    '{8'hF7, 1'b0, 1'b0, 0, 21'h0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 0, 21'h0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 0, 21'h0, 21'h0},
    '{8'hBF, 1'b0, 1'b1, 1, 21'h1FFFFF, 21'h0},
    '{8'hC0, 1'b0, 1'b0, 0, 21'h0, 21'h0},
    '{8'h80, 1'b0, 1'b1, 1, 21'h000000, 21'h0},
    '{8'hED, 1'b0, 1'b0, 0, 21'h0, 21'h0},
    '{8'hA0, 1'b0, 1'b0, 0, 21'h0, 21'h0},
    '{8'h80, 1'b0, 1'b1, 1, 21'h00D800, 21'h0},
    '{8'hE2, 1'b0, 1'b0, 0, 21'h0, 21'h0},
    '{8'h41, 1'b0, 1'b1, 2, ReplacementChar, 21'h000041},
    '{8'hC3, 1'b0, 1'b0, 0, 21'h0, 21'h0},
    '{8'hF0, 1'b1, 1'b1, 2, ReplacementChar, ReplacementChar},
    '{8'hE0, 1'b1, 1'b1, 1, ReplacementChar, 21'h0},
    '{8'h41, 1'b1, 1'b1, 1, 21'h000041, 21'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  u8dec_in_if  in_bus ();
  u8dec_out_if out_bus ();

  utf8_decoder_with_replacement_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  exp_t    owed_bytes;
  code_t   gathered_bits;
  code_t   step_cps [2];
  int      step_count;
  result_t pending_code_points [$];
  int      error_count;
  int      accepted_bytes;
  int      idle_cycles;
  int      sent_bytes;
  int      src_idle_pct;
  int      snk_stall_pct;

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void emit_cp(code_t cp);
    step_cps[step_count] = cp;
    step_count++;
  endfunction

  function automatic void open_sequence(byte_t b);
    if (!b[7]) begin
      emit_cp({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      gathered_bits = {16'd0, b[4:0]};
      owed_bytes    = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      gathered_bits = {17'd0, b[3:0]};
      owed_bytes    = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      gathered_bits = {18'd0, b[2:0]};
      owed_bytes    = 2'd3;
    end else begin
      emit_cp(ReplacementChar);
    end
  endfunction

  function automatic void decode_byte(byte_t b, logic eot);
    step_count = 0;
    if (owed_bytes != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        gathered_bits = {gathered_bits[CodeW-7:0], b[5:0]};
        owed_bytes    = owed_bytes - 2'd1;
        if (owed_bytes == 2'd0) begin
          emit_cp(gathered_bits);
          gathered_bits = '0;
        end
      end else begin
        emit_cp(ReplacementChar);
        owed_bytes    = '0;
        gathered_bits = '0;
        open_sequence(b);
      end
    end else begin
      open_sequence(b);
    end
    if (eot) begin
      if (owed_bytes != 2'd0) begin
        emit_cp(ReplacementChar);
      end
      owed_bytes    = '0;
      gathered_bits = '0;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    code_t   cps [2];
    int      n;
    bit      moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        got   = '{out_bus.code_point, out_bus.run_last, out_bus.text_done};
        if (pending_code_points.size() == 0) begin
          report_mismatch($sformatf("unexpected code point %h", got.code_point));
        end else begin
          want = pending_code_points.pop_front();
          if (got.code_point !== want.code_point) begin
            report_mismatch($sformatf("code_point %h, wanted %h",
                                      got.code_point, want.code_point));
          end
          if (got.run_last !== want.run_last) begin
            report_mismatch($sformatf("run_last %b, wanted %b for %h",
                                      got.run_last, want.run_last, want.code_point));
          end
          if (got.text_done !== want.text_done) begin
            report_mismatch($sformatf("text_done %b, wanted %b for %h",
                                      got.text_done, want.text_done, want.code_point));
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        decode_byte(in_bus.byte_in, in_bus.end_of_text);
        n   = step_count;
        cps = step_cps;
        if (accepted_bytes < DirRows && dir_rows[accepted_bytes].typed) begin
          n      = dir_rows[accepted_bytes].n;
          cps[0] = dir_rows[accepted_bytes].cp0;
          cps[1] = dir_rows[accepted_bytes].cp1;
        end
        for (int i = 0; i < n; i++) begin
          pending_code_points.push_back('{cps[i], i == n - 1,
                                          in_bus.end_of_text && (i == n - 1)});
        end
        accepted_bytes++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic send_byte(byte_t b, logic eot);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.byte_in     <= b;
    in_bus.end_of_text <= eot;
    do @(posedge clk); while (!in_bus.ready);
    sent_bytes++;
  endtask

  function automatic byte_t lead_of(int len);
    case (len)
      1:       return {1'b0, 7'($urandom)};
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic byte_t tail_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic send_random_text();
    byte_t text [$];
    int    units;
    int    len;
    units = $urandom_range(1, 10);
    for (int u = 0; u < units; u++) begin
      case ($urandom_range(0, 9))
        7: begin
          len = $urandom_range(2, 4);
          text.push_back(lead_of(len));
          repeat ($urandom_range(0, len - 2)) text.push_back(tail_byte());
        end
        8: begin
          text.push_back($urandom_range(0, 1) ? tail_byte() : 8'($urandom_range(8'hF8, 8'hFF)));
        end
        9: begin
          text.push_back(8'($urandom));
        end
        default: begin
          len = $urandom_range(1, 4);
          text.push_back(lead_of(len));
          repeat (len - 1) text.push_back(tail_byte());
        end
      endcase
    end
    foreach (text[i]) begin
      send_byte(text[i], i == text.size() - 1);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.byte_in     = '0;
    in_bus.end_of_text = 1'b0;
    out_bus.ready      = 1'b0;
    owed_bytes         = '0;
    gathered_bits      = '0;
    error_count        = 0;
    accepted_bytes     = 0;
    idle_cycles        = 0;
    sent_bytes         = 0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].eot);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct <= 0;  end
        1: begin src_idle_pct = 78; snk_stall_pct <= 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct <= 78; end
        default: begin src_idle_pct = 17; snk_stall_pct <= 17; end
      endcase
      while (sent_bytes < DirRows + (phase + 1) * PhaseItems) begin
        send_random_text();
      end
    end
    in_bus.valid <= 1'b0;

    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (DrainTail) @(posedge clk);
    if (pending_code_points.size() != 0) begin
      report_mismatch($sformatf("%0d code points never arrived", pending_code_points.size()));
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
